// File: hdl/rgb_hsv_converter_top_defines.svh
// Assertion macros for the RGB/HSV converter.
`ifndef RGB_HSV_CONVERTER_TOP_DEFINES_SVH
`define RGB_HSV_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RHC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rhc_pkg.sv
package rhc_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int HUE_BITS     = 16;
	localparam int QUO_BITS     = (CHANNEL_BITS > HUE_BITS + 1) ? CHANNEL_BITS : HUE_BITS + 1;

	localparam logic KIND_RGB2HSV = 1'b0;
	localparam logic KIND_HSV2RGB = 1'b1;

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	typedef struct packed {
		logic                    kind;
		logic [CHANNEL_BITS-1:0] red_in;
		logic [CHANNEL_BITS-1:0] green_in;
		logic [CHANNEL_BITS-1:0] blue_in;
		logic [HUE_BITS-1:0]     hue_in;
		logic [CHANNEL_BITS-1:0] sat_in;
		logic [CHANNEL_BITS-1:0] val_in;
	} in_word_t;

	typedef struct packed {
		logic                    kind_out;
		logic [CHANNEL_BITS-1:0] red_out;
		logic [CHANNEL_BITS-1:0] green_out;
		logic [CHANNEL_BITS-1:0] blue_out;
		logic [HUE_BITS-1:0]     hue_out;
		logic [CHANNEL_BITS-1:0] sat_out;
		logic [CHANNEL_BITS-1:0] val_out;
	} out_word_t;

endpackage

// File: hdl/rhc_div.sv
module rhc_div #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 9,
	parameter int QUO_W = 17
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);
	// radix-2 restoring divider, one quotient bit per stage
	logic [NUM_W+QUO_W-1:0] num_x;
	logic [DEN_W-1:0]       rem_s [1:QUO_W];
	logic [QUO_W-1:0]       low_s [1:QUO_W];
	logic [QUO_W-1:0]       quo_s [1:QUO_W];
	logic [DEN_W-1:0]       den_s [1:QUO_W];

	assign num_x = {{QUO_W{1'b0}}, num};

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		logic [DEN_W-1:0] rem_i;
		logic [QUO_W-1:0] low_i;
		logic [QUO_W-1:0] quo_i;
		logic [DEN_W-1:0] den_i;
		logic [DEN_W:0]   trial;
		logic             fits;

		if (i == 0) begin : g_head
			assign rem_i = DEN_W'(num_x >> QUO_W);
			assign low_i = num_x[QUO_W-1:0];
			assign quo_i = '0;
			assign den_i = den;
		end else begin : g_tail
			assign rem_i = rem_s[i];
			assign low_i = low_s[i];
			assign quo_i = quo_s[i];
			assign den_i = den_s[i];
		end

		assign trial = {rem_i, low_i[QUO_W-1]};
		assign fits  = trial >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= fits ? DEN_W'(trial - {1'b0, den_i}) : DEN_W'(trial);
				low_s[i+1] <= low_i << 1;
				quo_s[i+1] <= {quo_i[QUO_W-2:0], fits};
				den_s[i+1] <= den_i;
			end
		end
	end

	assign quo = quo_s[QUO_W];
endmodule

// File: hdl/rgb_hsv_converter_top.sv
// RGB/HSV pixel converter. Each word is converted RGB to HSV (kind 0) or HSV to RGB
// (kind 1); fields of the unused direction read as zero. Channels, saturation and value
// are fractions of 255, hue a fraction of 65536 of a turn, all rounded to nearest.
// Throughput is one pixel per clock while pixel_stall is low. The path runs through three
// operand stages, then one stage per quotient bit of the radix-2 divider pipelines, then
// the output register. A two-entry output buffer keeps the input open while a finished
// word waits; pixel_stall rises only when both are full.
module rgb_hsv_converter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  rhc_pkg::in_word_t  pixel,
	output logic               result_valid,
	input  logic               result_stall,
	output rhc_pkg::out_word_t result
);
	import rhc_pkg::*;

	localparam int C    = CHANNEL_BITS;
	localparam int H    = HUE_BITS;
	localparam int QW   = QUO_BITS;
	localparam int SN_W = 2*C + 1;
	localparam int SD_W = C + 1;
	localparam int HN_W = C + H + 5;
	localparam int HD_W = C + 4;
	localparam int PY_W = 2*C;
	localparam int QF_W = 2*C + H;

	localparam logic [C-1:0]    CM        = '1;
	localparam logic [C-1:0]    CM_HALF   = CM >> 1;
	localparam logic [C+H-1:0]  TURN_DEN  = {CM, {H{1'b0}}};
	localparam logic [C+H-1:0]  TURN_HALF = TURN_DEN >> 1;
	// reciprocal of 2^C - 1, exact for any dividend below 2^(2C)
	localparam logic [PY_W-1:0] RECIP     = PY_W'(((64'd1 << (3*C-1)) + (64'd1 << C) - 64'd2)
		/ ((64'd1 << C) - 64'd1));

	typedef struct packed {
		logic           kind;
		sector_t        sector;
		logic [C-1:0]   val;
		logic [C-1:0]   sat_c;
		logic [C-1:0]   diff;
		logic [C+2:0]   hue6;
		logic [C+H-1:0] fs;
		logic           grey;
		logic           black;
	} mid_t;

	typedef struct packed {
		logic         kind;
		sector_t      sector;
		logic [C-1:0] val;
		logic         grey;
		logic         black;
	} side_t;

	typedef struct packed {
		side_t        side;
		logic [C-1:0] p;
		logic [C-1:0] q;
		logic [C-1:0] t;
	} lane_t;

	function automatic logic [C-1:0] div_cm(input logic [PY_W-1:0] y);
		logic [2*PY_W-1:0] prod;
		prod = (2*PY_W)'(y) * (2*PY_W)'(RECIP);
		return prod[3*C-1 +: C];
	endfunction

	logic en;

	// stage 1: input register
	logic     vld_s1;
	in_word_t pix_s1;

	// stage 1 logic
	logic [C-1:0]   mx;
	logic [C-1:0]   mn;
	logic [C+2:0]   rr, gg, bb, d3;
	logic [C+2:0]   hue6;
	logic [H+2:0]   h6;
	logic [H-1:0]   frac;
	logic [C+H-1:0] fs;
	mid_t           mid;

	// stage 2
	logic vld_s2;
	mid_t mid_s2;

	logic [C+H-1:0]  inner_q;
	logic [C+H-1:0]  inner_t;
	logic [C+2:0]    d6;
	logic [QF_W-1:0] q_full;
	logic [QF_W-1:0] t_full;

	// stage 3
	logic            vld_s3;
	side_t           side_s3;
	logic [SN_W-1:0] sat_num_s3;
	logic [SD_W-1:0] sat_den_s3;
	logic [HN_W-1:0] hue_num_s3;
	logic [HD_W-1:0] hue_den_s3;
	logic [PY_W-1:0] p_y_s3;
	logic [PY_W-1:0] q_y_s3;
	logic [PY_W-1:0] t_y_s3;

	// divider stages
	lane_t lane_n;
	logic  vld_s  [1:QW];
	lane_t side_s [1:QW];
	logic [QW-1:0] sat_quo, hue_quo;

	side_t        side_l;
	logic [C-1:0] p_l, q_l, t_l;
	out_word_t    word_l;
	logic         take;
	logic         pop;

	logic      out_vld_q, out_vld_d;
	logic      skid_vld_q, skid_vld_d;
	out_word_t out_q;
	out_word_t skid_q;
	logic      load_out, from_skid, load_skid;

	assign en          = !skid_vld_q;
	assign pixel_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int i = 1; i <= QW; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1   <= pixel_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s[1] <= vld_s3;
			for (int i = 2; i <= QW; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= pixel;
		end
	end

	// max, min, sector numerator, hue split
	always_comb begin
		rr = (C+3)'(pix_s1.red_in);
		gg = (C+3)'(pix_s1.green_in);
		bb = (C+3)'(pix_s1.blue_in);
		mn = pix_s1.red_in;
		if (pix_s1.green_in < mn) begin
			mn = pix_s1.green_in;
		end
		if (pix_s1.blue_in < mn) begin
			mn = pix_s1.blue_in;
		end
		if (pix_s1.red_in >= pix_s1.green_in && pix_s1.red_in >= pix_s1.blue_in) begin
			mx   = pix_s1.red_in;
			d3   = (C+3)'(mx - mn);
			hue6 = (gg >= bb) ? gg - bb : (d3 << 2) + (d3 << 1) - (bb - gg);
		end else if (pix_s1.green_in >= pix_s1.blue_in) begin
			mx   = pix_s1.green_in;
			d3   = (C+3)'(mx - mn);
			hue6 = (bb >= rr) ? (d3 << 1) + (bb - rr) : (d3 << 1) - (rr - bb);
		end else begin
			mx   = pix_s1.blue_in;
			d3   = (C+3)'(mx - mn);
			hue6 = (rr >= gg) ? (d3 << 2) + (rr - gg) : (d3 << 2) - (gg - rr);
		end
	end

	assign h6   = (H+3)'(pix_s1.hue_in) * (H+3)'(6);
	assign frac = h6[H-1:0];
	assign fs   = (C+H)'(frac) * (C+H)'(pix_s1.sat_in);

	always_comb begin
		mid.kind   = pix_s1.kind;
		mid.sector = sector_t'(h6[H+2:H]);
		mid.val    = (pix_s1.kind == KIND_HSV2RGB) ? pix_s1.val_in : mx;
		mid.sat_c  = CM - pix_s1.sat_in;
		mid.diff   = mx - mn;
		mid.hue6   = hue6;
		mid.fs     = fs;
		mid.grey   = (mx == mn);
		mid.black  = (mx == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s2 <= mid;
		end
	end

	// numerators and divisors
	assign inner_q = TURN_DEN - mid_s2.fs;
	assign inner_t = {mid_s2.sat_c, {H{1'b0}}} + mid_s2.fs;
	assign d6      = ((C+3)'(mid_s2.diff) << 2) + ((C+3)'(mid_s2.diff) << 1);
	assign q_full  = QF_W'(mid_s2.val) * QF_W'(inner_q) + QF_W'(TURN_HALF);
	assign t_full  = QF_W'(mid_s2.val) * QF_W'(inner_t) + QF_W'(TURN_HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.kind   <= mid_s2.kind;
			side_s3.sector <= mid_s2.sector;
			side_s3.val    <= mid_s2.val;
			side_s3.grey   <= mid_s2.grey;
			side_s3.black  <= mid_s2.black;
			sat_num_s3 <= ((SN_W'(mid_s2.diff) * SN_W'(CM)) << 1) + SN_W'(mid_s2.val);
			sat_den_s3 <= {mid_s2.val, 1'b0};
			hue_num_s3 <= (HN_W'(mid_s2.hue6) << (H + 1)) + HN_W'(d6);
			hue_den_s3 <= (HD_W'(mid_s2.diff) << 3) + (HD_W'(mid_s2.diff) << 2);
			p_y_s3     <= PY_W'(mid_s2.val) * PY_W'(mid_s2.sat_c) + PY_W'(CM_HALF);
			q_y_s3     <= q_full[H +: PY_W];
			t_y_s3     <= t_full[H +: PY_W];
		end
	end

	// p, q and t divide by the constant 2^C - 1
	always_comb begin
		lane_n.side = side_s3;
		lane_n.p    = div_cm(p_y_s3);
		lane_n.q    = div_cm(q_y_s3);
		lane_n.t    = div_cm(t_y_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= lane_n;
			for (int i = 2; i <= QW; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	rhc_div #(.NUM_W(SN_W), .DEN_W(SD_W), .QUO_W(QW)) u_sat_div (
		.clk(clk), .en(en), .num(sat_num_s3), .den(sat_den_s3), .quo(sat_quo)
	);

	rhc_div #(.NUM_W(HN_W), .DEN_W(HD_W), .QUO_W(QW)) u_hue_div (
		.clk(clk), .en(en), .num(hue_num_s3), .den(hue_den_s3), .quo(hue_quo)
	);

	assign side_l = side_s[QW].side;
	assign p_l    = side_s[QW].p;
	assign q_l    = side_s[QW].q;
	assign t_l    = side_s[QW].t;

	always_comb begin
		word_l          = '0;
		word_l.kind_out = side_l.kind;
		if (side_l.kind == KIND_RGB2HSV) begin
			word_l.val_out = side_l.val;
			word_l.sat_out = side_l.black ? '0 : sat_quo[C-1:0];
			word_l.hue_out = side_l.grey ? '0 : hue_quo[H-1:0];
		end else begin
			case (side_l.sector)
				SEC_RED: begin
					word_l.red_out   = side_l.val;
					word_l.green_out = t_l;
					word_l.blue_out  = p_l;
				end
				SEC_YELLOW: begin
					word_l.red_out   = q_l;
					word_l.green_out = side_l.val;
					word_l.blue_out  = p_l;
				end
				SEC_GREEN: begin
					word_l.red_out   = p_l;
					word_l.green_out = side_l.val;
					word_l.blue_out  = t_l;
				end
				SEC_CYAN: begin
					word_l.red_out   = p_l;
					word_l.green_out = q_l;
					word_l.blue_out  = side_l.val;
				end
				SEC_BLUE: begin
					word_l.red_out   = t_l;
					word_l.green_out = p_l;
					word_l.blue_out  = side_l.val;
				end
				default: begin
					word_l.red_out   = side_l.val;
					word_l.green_out = p_l;
					word_l.blue_out  = q_l;
				end
			endcase
		end
	end

	// output register plus skid entry
	assign take = vld_s[QW] && en;
	assign pop  = out_vld_q && !result_stall;

	always_comb begin
		out_vld_d  = out_vld_q;
		skid_vld_d = skid_vld_q;
		load_out   = 1'b0;
		from_skid  = 1'b0;
		load_skid  = 1'b0;
		if (skid_vld_q) begin
			if (pop || !out_vld_q) begin
				load_out   = 1'b1;
				from_skid  = 1'b1;
				out_vld_d  = 1'b1;
				skid_vld_d = 1'b0;
			end
		end else if (take) begin
			if (!out_vld_q || pop) begin
				load_out  = 1'b1;
				out_vld_d = 1'b1;
			end else begin
				load_skid  = 1'b1;
				skid_vld_d = 1'b1;
			end
		end else if (pop) begin
			out_vld_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q  <= out_vld_d;
			skid_vld_q <= skid_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= from_skid ? skid_q : word_l;
		end
		if (load_skid) begin
			skid_q <= word_l;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;
endmodule

// File: hdl/rhc_checker.sv
`include "rgb_hsv_converter_top_defines.svh"

module rhc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pixel_valid,
	input logic               pixel_stall,
	input rhc_pkg::in_word_t  pixel,
	input logic               result_valid,
	input logic               result_stall,
	input rhc_pkg::out_word_t result
);
	import rhc_pkg::*;

	`RHC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result word changed or dropped")
	`RHC_ASSERT_NOW(a_hsv_rgb_zero, result_valid && result.kind_out == KIND_RGB2HSV, result.red_out == '0 && result.green_out == '0 && result.blue_out == '0, "RGB fields not zero in RGB to HSV word")
	`RHC_ASSERT_NOW(a_rgb_hsv_zero, result_valid && result.kind_out == KIND_HSV2RGB, result.hue_out == '0 && result.sat_out == '0 && result.val_out == '0, "HSV fields not zero in HSV to RGB word")
	`RHC_ASSERT_NOW(a_stall_cause, $rose(pixel_stall), $past(result_valid && result_stall), "input stalled without output back-pressure")
endmodule

bind rgb_hsv_converter_top rhc_checker u_rhc_checker (.*);

// File: verif/rgb_hsv_converter_top_test.sv
`timescale 1ns / 100ps

module rgb_hsv_converter_top_test;
	import rhc_pkg::*;

	localparam longint CH_MAX   = (64'd1 << CHANNEL_BITS) - 1;
	localparam longint HUE_ONE  = 64'd1 << HUE_BITS;
	localparam int     LATENCY  = QUO_BITS + 4;
	localparam int     N_RANDOM = 1300;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	in_word_t pixel = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_word_t result;

	in_word_t pixel_queue[$];
	out_word_t expected_pixels[$];
	int mismatches = 0;
	int words_in = 0;
	int words_out = 0;
	int n_hsv = 0;
	int n_rgb = 0;
	longint cycles = 0;
	bit feed_hold = 1'b0;
	bit stall_hold = 1'b0;
	bit feeding_done = 1'b0;

	rgb_hsv_converter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint round_div(longint num, longint den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic out_word_t convert_pixel(in_word_t w);
		out_word_t o;
		longint r, g, b, mx, mn, d, n, h, s, v, h6, sec, fr, dn, p, q, t;
		o = '0;
		o.kind_out = w.kind;
		if (w.kind == KIND_RGB2HSV) begin
			r = longint'(w.red_in);
			g = longint'(w.green_in);
			b = longint'(w.blue_in);
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn;
			s = (mx == 0) ? 64'd0 : round_div(d * CH_MAX, mx);
			o.val_out = CHANNEL_BITS'(mx);
			o.sat_out = CHANNEL_BITS'(s);
			if (d != 0) begin
				if (mx == r)
					n = (g >= b) ? (g - b) : (6 * d - (b - g));
				else if (mx == g)
					n = (b >= r) ? (2 * d + (b - r)) : (2 * d - (r - b));
				else
					n = (r >= g) ? (4 * d + (r - g)) : (4 * d - (g - r));
				h = round_div(n * HUE_ONE, 6 * d) % HUE_ONE;
				o.hue_out = HUE_BITS'(h);
			end
		end else begin
			h = longint'(w.hue_in);
			s = longint'(w.sat_in);
			v = longint'(w.val_in);
			h6 = h * 6;
			sec = h6 >> HUE_BITS;
			fr = h6 % HUE_ONE;
			dn = CH_MAX * HUE_ONE;
			p = round_div(v * (CH_MAX - s), CH_MAX);
			q = round_div(v * (dn - fr * s), dn);
			t = round_div(v * (dn - (HUE_ONE - fr) * s), dn);
			case (sector_t'(sec))
				SEC_RED: begin
					o.red_out = CHANNEL_BITS'(v);
					o.green_out = CHANNEL_BITS'(t);
					o.blue_out = CHANNEL_BITS'(p);
				end
				SEC_YELLOW: begin
					o.red_out = CHANNEL_BITS'(q);
					o.green_out = CHANNEL_BITS'(v);
					o.blue_out = CHANNEL_BITS'(p);
				end
				SEC_GREEN: begin
					o.red_out = CHANNEL_BITS'(p);
					o.green_out = CHANNEL_BITS'(v);
					o.blue_out = CHANNEL_BITS'(t);
				end
				SEC_CYAN: begin
					o.red_out = CHANNEL_BITS'(p);
					o.green_out = CHANNEL_BITS'(q);
					o.blue_out = CHANNEL_BITS'(v);
				end
				SEC_BLUE: begin
					o.red_out = CHANNEL_BITS'(t);
					o.green_out = CHANNEL_BITS'(p);
					o.blue_out = CHANNEL_BITS'(v);
				end
				default: begin
					o.red_out = CHANNEL_BITS'(v);
					o.green_out = CHANNEL_BITS'(p);
					o.blue_out = CHANNEL_BITS'(q);
				end
			endcase
		end
		return o;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// stall as seen at the last rising edge
	logic pixel_stall_q = 1'b0;

	// driver
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (pixel_valid && pixel_stall_q) begin
				// hold
			end else if (send_gap > 0 || feed_hold || pixel_queue.size() == 0) begin
				if (send_gap > 0) send_gap <= send_gap - 1;
				pixel_valid <= 1'b0;
			end else begin
				pixel <= pixel_queue.pop_front();
				pixel_valid <= 1'b1;
				send_gap <= gap_len();
			end
		end
	end

	always @(posedge clk) begin
		pixel_stall_q <= pixel_stall;
		cycles <= cycles + 1;
		if (arst_n && pixel_valid && !pixel_stall) begin
			expected_pixels.push_back(convert_pixel(pixel));
			words_in <= words_in + 1;
			if (pixel.kind == KIND_RGB2HSV) n_hsv <= n_hsv + 1;
			else n_rgb <= n_rgb + 1;
		end
	end

	// monitor
	out_word_t want;
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			words_out <= words_out + 1;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %p", result);
			end else begin
				want = expected_pixels.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, result);
				end
			end
		end
	end

	// receiver stall
	int rx_gap = 0;
	int rx_run = 0;
	always @(negedge clk) begin
		if (stall_hold) begin
			result_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			result_stall <= 1'b1;
		end else if (rx_run > 0) begin
			rx_run <= rx_run - 1;
			result_stall <= 1'b0;
		end else begin
			result_stall <= 1'b0;
			if ($urandom_range(0, 3) == 0) rx_run <= $urandom_range(20, 80);
			else rx_gap <= gap_len();
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic in_word_t rand_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(in_word_t)-1:0];
	endfunction

	function automatic in_word_t rand_rgb();
		in_word_t w;
		w = rand_word();
		w.kind = KIND_RGB2HSV;
		case ($urandom_range(0, 5))
			0: w.green_in = w.red_in;
			1: w.blue_in = w.green_in;
			2: begin
				w.green_in = w.red_in; w.blue_in = w.red_in;
			end
			default: ;
		endcase
		return w;
	endfunction

	function automatic in_word_t rand_hsv();
		in_word_t w;
		w = rand_word();
		w.kind = KIND_HSV2RGB;
		if ($urandom_range(0, 7) == 0) w.sat_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
		if ($urandom_range(0, 7) == 0) w.val_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
		return w;
	endfunction

	function automatic in_word_t make_rgb(int r, int g, int b);
		in_word_t w;
		w = rand_word();
		w.kind = KIND_RGB2HSV;
		w.red_in = CHANNEL_BITS'(r);
		w.green_in = CHANNEL_BITS'(g);
		w.blue_in = CHANNEL_BITS'(b);
		return w;
	endfunction

	function automatic in_word_t make_hsv(int h, int s, int v);
		in_word_t w;
		w = rand_word();
		w.kind = KIND_HSV2RGB;
		w.hue_in = HUE_BITS'(h);
		w.sat_in = CHANNEL_BITS'(s);
		w.val_in = CHANNEL_BITS'(v);
		return w;
	endfunction

	task automatic wait_drained();
		while (pixel_queue.size() != 0 || pixel_valid || expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int i;
		int k;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, ties, grey, black, every sector, hue wrap
		pixel_queue.push_back(make_rgb(0, 0, 0));
		pixel_queue.push_back(make_rgb(255, 255, 255));
		pixel_queue.push_back(make_rgb(128, 128, 128));
		pixel_queue.push_back(make_rgb(255, 0, 0));
		pixel_queue.push_back(make_rgb(0, 255, 0));
		pixel_queue.push_back(make_rgb(0, 0, 255));
		pixel_queue.push_back(make_rgb(255, 255, 0));
		pixel_queue.push_back(make_rgb(0, 255, 255));
		pixel_queue.push_back(make_rgb(255, 0, 255));
		pixel_queue.push_back(make_rgb(255, 0, 1));
		pixel_queue.push_back(make_rgb(1, 0, 0));
		pixel_queue.push_back(make_rgb(200, 10, 200));
		pixel_queue.push_back(make_hsv(0, 255, 255));
		pixel_queue.push_back(make_hsv(65535, 255, 255));
		pixel_queue.push_back(make_hsv(0, 0, 0));
		pixel_queue.push_back(make_hsv(12345, 0, 200));
		for (k = 0; k < 6; k++)
			pixel_queue.push_back(make_hsv(k * 10923 + 5000, 255, 255));
		pixel_queue.push_back(make_hsv(32768, 128, 77));
		wait_drained();

		for (i = 0; i < N_RANDOM / 2; i++)
			pixel_queue.push_back($urandom_range(0, 1) ? rand_rgb() : rand_hsv());

		// long receiver hold while the sender keeps offering words
		stall_hold = 1'b1;
		repeat (3 * LATENCY + 40) @(posedge clk);
		stall_hold = 1'b0;

		// wait until every result is back, then pause the sender while the queue is refilled
		wait_drained();
		feed_hold = 1'b1;
		for (i = 0; i < N_RANDOM / 2; i++)
			pixel_queue.push_back($urandom_range(0, 1) ? rand_rgb() : rand_hsv());
		repeat (5) @(posedge clk);
		feed_hold = 1'b0;
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);

		$display("%0d words in (%0d rgb->hsv, %0d hsv->rgb), %0d words out",
			words_in, n_hsv, n_rgb, words_out);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d words missing", mismatches,
				expected_pixels.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: rgb_hsv_converter_top.f
+incdir+hdl
hdl/rhc_pkg.sv
hdl/rhc_div.sv
hdl/rgb_hsv_converter_top.sv
hdl/rhc_checker.sv
verif/rgb_hsv_converter_top_test.sv
